FILE: rtl/usp_pkg.sv
package usp_pkg;

  // parser phase, one-hot
  typedef enum logic [8:0] {
    PH_PROTO  = 9'b000000001,
    PH_SKIP_A = 9'b000000010,
    PH_SKIP_B = 9'b000000100,
    PH_HOST   = 9'b000001000,
    PH_PORT   = 9'b000010000,
    PH_PATH   = 9'b000100000,
    PH_SEARCH = 9'b001000000,
    PH_HASH   = 9'b010000000,
    PH_STOP   = 9'b100000000
  } phase_e;

  // component codes
  localparam logic [2:0] COMP_PROTOCOL = 3'd0;
  localparam logic [2:0] COMP_HOST     = 3'd1;
  localparam logic [2:0] COMP_PATH     = 3'd2;
  localparam logic [2:0] COMP_SEARCH   = 3'd3;
  localparam logic [2:0] COMP_HASH     = 3'd4;

  // record kinds
  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // delimiter and digit characters
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned PortWidth = 16;
  localparam logic [PortWidth-1:0] PORT_MAX = '1;

  // one result word
  typedef struct packed {
    logic                 kind;
    logic [2:0]           comp;
    logic [7:0]           ch;
    logic [PortWidth-1:0] port;
    logic                 bad;
    logic                 last;
  } record_t;

endpackage

FILE: rtl/url_component_splitter.sv
// url component splitter: tags each url byte with its component
// outputs are driven from a registered two-slot queue, not from the input directly
// throughput: 1 input word per cycle while in_stall_o is low; a final byte that is also content
//   yields two result words and stalls the input until the second word moves to the first slot
// reset: rst_ni low clears the parser phase, port accumulator, port error flag and output valids
module url_component_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_url_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [2:0]  component_o,
  output logic [7:0]  char_out_o,
  output logic [15:0] port_value_o,
  output logic        port_bad_o,
  output logic        last_record_o
);

  usp_pkg::phase_e                 phase_q, phase_d, phase_next;
  logic [usp_pkg::PortWidth-1:0]   port_accum_q, port_accum_d, port_next;
  logic                            port_error_q, port_error_d, error_next;

  usp_pkg::record_t slot_a_q, slot_a_d, slot_b_q, slot_b_d;
  logic             a_valid_q, a_valid_d, b_valid_q, b_valid_d;

  logic       in_acc, out_pop;
  logic       is_colon, is_slash, is_quest, is_hash, is_digit;
  logic       comp_valid;
  logic [2:0] comp_code;
  logic [7:0] digit;
  logic [19:0] port_prod;

  usp_pkg::record_t rec_content, rec_summary;

  // handshakes
  assign out_pop    = a_valid_q && !out_stall_i;
  assign in_stall_o = b_valid_q || (a_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // character classes
  assign is_colon = char_in_i == usp_pkg::CH_COLON;
  assign is_slash = char_in_i == usp_pkg::CH_SLASH;
  assign is_quest = char_in_i == usp_pkg::CH_QUEST;
  assign is_hash  = char_in_i == usp_pkg::CH_HASH;
  assign is_digit = (char_in_i >= usp_pkg::CH_ZERO) && (char_in_i <= usp_pkg::CH_NINE);
  assign digit    = char_in_i - usp_pkg::CH_ZERO;

  // port times ten plus digit, as shifts and adds
  assign port_prod = {1'b0, port_accum_q, 3'b000} + {3'b000, port_accum_q, 1'b0}
                   + {12'd0, digit};

  // phase transition and content tagging
  always_comb begin
    phase_next = phase_q;
    port_next  = port_accum_q;
    error_next = port_error_q;
    comp_valid = 1'b0;
    comp_code  = usp_pkg::COMP_PROTOCOL;
    unique case (phase_q)
      usp_pkg::PH_PROTO: begin
        if (is_colon) begin
          phase_next = usp_pkg::PH_SKIP_A;
        end else begin
          comp_valid = 1'b1;
          comp_code  = usp_pkg::COMP_PROTOCOL;
        end
      end
      usp_pkg::PH_SKIP_A: begin
        phase_next = usp_pkg::PH_SKIP_B;
      end
      usp_pkg::PH_SKIP_B: begin
        phase_next = usp_pkg::PH_HOST;
      end
      usp_pkg::PH_HOST: begin
        if (is_slash) begin
          phase_next = usp_pkg::PH_PATH;
        end else if (is_colon) begin
          phase_next = usp_pkg::PH_PORT;
        end else if (is_quest) begin
          phase_next = usp_pkg::PH_SEARCH;
        end else if (is_hash) begin
          phase_next = usp_pkg::PH_HASH;
        end else begin
          comp_valid = 1'b1;
          comp_code  = usp_pkg::COMP_HOST;
        end
      end
      usp_pkg::PH_PORT: begin
        if (is_slash) begin
          phase_next = usp_pkg::PH_PATH;
        end else if (is_colon) begin
          phase_next = usp_pkg::PH_STOP;
        end else if (is_quest) begin
          phase_next = usp_pkg::PH_SEARCH;
        end else if (is_hash) begin
          phase_next = usp_pkg::PH_HASH;
        end else if (is_digit) begin
          // saturate on overflow
          if (port_prod[19:16] != 4'd0) begin
            port_next  = usp_pkg::PORT_MAX;
            error_next = 1'b1;
          end else begin
            port_next = port_prod[15:0];
          end
        end else begin
          error_next = 1'b1;
        end
      end
      usp_pkg::PH_PATH: begin
        if (is_colon) begin
          phase_next = usp_pkg::PH_STOP;
        end else if (is_quest) begin
          phase_next = usp_pkg::PH_SEARCH;
        end else if (is_hash) begin
          phase_next = usp_pkg::PH_HASH;
        end else begin
          comp_valid = 1'b1;
          comp_code  = usp_pkg::COMP_PATH;
        end
      end
      usp_pkg::PH_SEARCH: begin
        if (is_colon || is_quest) begin
          phase_next = usp_pkg::PH_STOP;
        end else if (is_hash) begin
          phase_next = usp_pkg::PH_HASH;
        end else begin
          comp_valid = 1'b1;
          comp_code  = usp_pkg::COMP_SEARCH;
        end
      end
      usp_pkg::PH_HASH: begin
        if (is_colon || is_quest || is_hash) begin
          phase_next = usp_pkg::PH_STOP;
        end else begin
          comp_valid = 1'b1;
          comp_code  = usp_pkg::COMP_HASH;
        end
      end
      default: begin
        phase_next = usp_pkg::PH_STOP;
      end
    endcase
  end

  // result words for this byte
  always_comb begin
    rec_content      = '0;
    rec_content.kind = usp_pkg::KIND_CONTENT;
    rec_content.comp = comp_code;
    rec_content.ch   = char_in_i;

    rec_summary      = '0;
    rec_summary.kind = usp_pkg::KIND_SUMMARY;
    rec_summary.port = port_next;
    rec_summary.bad  = error_next;
    rec_summary.last = 1'b1;
  end

  // state update, back to reset at end of url
  always_comb begin
    phase_d      = phase_q;
    port_accum_d = port_accum_q;
    port_error_d = port_error_q;
    if (in_acc) begin
      if (end_of_url_i) begin
        phase_d      = usp_pkg::PH_PROTO;
        port_accum_d = '0;
        port_error_d = 1'b0;
      end else begin
        phase_d      = phase_next;
        port_accum_d = port_next;
        port_error_d = error_next;
      end
    end
  end

  // two-slot output queue; input only taken when the queue is empty or its head drains this cycle
  always_comb begin
    slot_a_d  = slot_a_q;
    slot_b_d  = slot_b_q;
    a_valid_d = a_valid_q;
    b_valid_d = b_valid_q;
    if (in_acc) begin
      slot_a_d  = comp_valid ? rec_content : rec_summary;
      slot_b_d  = rec_summary;
      a_valid_d = comp_valid || end_of_url_i;
      b_valid_d = comp_valid && end_of_url_i;
    end else if (out_pop) begin
      slot_a_d  = slot_b_q;
      a_valid_d = b_valid_q;
      b_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= usp_pkg::PH_PROTO;
      port_accum_q <= '0;
      port_error_q <= 1'b0;
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      port_accum_q <= port_accum_d;
      port_error_q <= port_error_d;
      a_valid_q    <= a_valid_d;
      b_valid_q    <= b_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slot_a_q <= slot_a_d;
    slot_b_q <= slot_b_d;
  end

  // outputs
  assign out_valid_o   = a_valid_q;
  assign record_kind_o = slot_a_q.kind;
  assign component_o   = slot_a_q.comp;
  assign char_out_o    = slot_a_q.ch;
  assign port_value_o  = slot_a_q.port;
  assign port_bad_o    = slot_a_q.bad;
  assign last_record_o = slot_a_q.last;

`ifndef SYNTHESIS
  // second slot is never filled without the first
  assert property (@(posedge clk_i) disable iff (!rst_ni) b_valid_q |-> a_valid_q)
    else $error("second slot valid while first slot empty");

  // end of url always leaves a summary queued and parser state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_url_i) |=> (a_valid_q && (slot_a_q.last || (b_valid_q && slot_b_q.last))
      && phase_q == usp_pkg::PH_PROTO && port_accum_q == '0 && !port_error_q))
    else $error("end of url did not queue summary or clear state");

  // last flag only on summary words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_record_o) |-> (record_kind_o == usp_pkg::KIND_SUMMARY))
    else $error("last flag on a content word");

  // content words carry a defined component code and a zero port field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o == usp_pkg::KIND_CONTENT)
      |-> (component_o <= usp_pkg::COMP_HASH && port_value_o == '0))
    else $error("content word with bad component or port field");
`endif

endmodule
